FILE: sv/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg: shared constants and limiting helpers
// Widths, register indexes, limit codes and the saturate and wrap functions
// used by the resonant low-pass filter step.
// ----------------------------------------------------------------------------
package svf_pkg;

	// data widths
	localparam int STATE_W  = 40;   // low and band state
	localparam int OUT_W    = 20;   // filtered result
	localparam int CALC_W   = 43;   // internal datapath; products are wider (PROD_W)
	localparam int SAMPLE_W = 20;
	localparam int RES_W    = 8;
	localparam int INIT_W   = 19;
	localparam int GAIN_W   = 10;   // gain k, up to 512
	localparam int PROD_W   = CALC_W + GAIN_W + 1;

	// configuration register widths
	localparam int CUTOFF_W = 13;
	localparam int LMODE_W  = 2;
	localparam int LWIDTH_W = 6;
	localparam int LSTAGE_W = 3;

	// register indexes
	localparam logic [2:0] REG_CUTOFF    = 3'd0;
	localparam logic [2:0] REG_LMODE     = 3'd1;
	localparam logic [2:0] REG_LWIDTH    = 3'd2;
	localparam logic [2:0] REG_LSTAGE    = 3'd3;
	localparam logic [2:0] REG_INIT_LOW  = 3'd4;
	localparam logic [2:0] REG_INIT_BAND = 3'd5;

	// limit modes
	localparam logic [LMODE_W-1:0] LIM_NONE = 2'd0;
	localparam logic [LMODE_W-1:0] LIM_SAT  = 2'd1;
	localparam logic [LMODE_W-1:0] LIM_WRAP = 2'd2;

	// limit stages
	localparam logic [LSTAGE_W-1:0] STG_STATE = 3'd0;
	localparam logic [LSTAGE_W-1:0] STG_HP    = 3'd1;
	localparam logic [LSTAGE_W-1:0] STG_DAMP  = 3'd2;
	localparam logic [LSTAGE_W-1:0] STG_BINC  = 3'd3;
	localparam logic [LSTAGE_W-1:0] STG_LINC  = 3'd4;

	// gain special case and limit width clamp
	localparam logic [CUTOFF_W-1:0] CUTOFF_FULL = 13'h1FFE;
	localparam logic [GAIN_W-1:0]   GAIN_FULL   = 10'd512;
	localparam logic [LWIDTH_W-1:0] LWIDTH_MIN  = 6'd20;
	localparam logic [LWIDTH_W-1:0] LWIDTH_MAX  = 6'd32;

	// saturate a signed value to w bits
	function automatic logic signed [CALC_W-1:0] sat_to(
		input logic signed [CALC_W-1:0] v,
		input logic [6:0] w
	);
		logic fits;
		logic [CALC_W-1:0] hi;
		fits = 1'b1;
		for (int i = 0; i < CALC_W; i++) begin
			if ((i >= int'(w) - 1) && (v[i] != v[CALC_W-1]))
				fits = 1'b0;
			hi[i] = (i < int'(w) - 1);
		end
		if (fits)
			return v;
		else if (v[CALC_W-1])
			return signed'(~hi);
		else
			return signed'(hi);
	endfunction

	// keep the low w bits and sign extend from bit w-1
	function automatic logic signed [CALC_W-1:0] wrap_to(
		input logic signed [CALC_W-1:0] v,
		input logic [LWIDTH_W-1:0] w
	);
		logic [LWIDTH_W-1:0] sidx;
		logic [CALC_W-1:0] r;
		sidx = w - 6'd1;
		for (int i = 0; i < CALC_W; i++)
			r[i] = (i < int'(w)) ? v[i] : v[sidx];
		return signed'(r);
	endfunction

endpackage

FILE: sv/resonant_svf_lowpass_step.sv
// ----------------------------------------------------------------------------
// resonant_svf_lowpass_step: resonant two-integrator low-pass filter step
// Each sample updates the band and low state and yields one filtered item.
//
// Usage
//   s_* stream: one input item per sample (sample, resonance, restart flag).
//   m_* stream: one filtered item per input item, held in an output register.
//   APB port: cutoff word, limit mode, limit width, limit stage and the
//   restart values of the low and band state; write only while idle.
// Timing
//   A result is valid once its item has passed the four steps of the
//   sequencer (damping multiply, highpass sum, band multiply and update,
//   low multiply and update). One multiplier serves all three products;
//   s_tready is low while the sequencer runs and rises the cycle after the
//   low step, so the block takes no new item until the last one is done.
//   The next item is accepted while a result waits in the output register;
//   if the receiver still stalls when the next result is done, the last
//   step holds until the output register frees.
// Reset
//   arst_n clears the state, the configuration (limit width to 20) and the
//   output valid flag.
// ----------------------------------------------------------------------------
module resonant_svf_lowpass_step
	import svf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [19:0] sample, [27:20] resonance, [31:28] zero
	input  logic        s_tuser,   // [0] restart
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [19:0] filtered, [23:20] zero
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DAMP = 3'd1;
	localparam logic [2:0] ST_HP   = 3'd2;
	localparam logic [2:0] ST_BAND = 3'd3;
	localparam logic [2:0] ST_LOW  = 3'd4;

	logic [2:0] state_q;

	// configuration registers
	logic [CUTOFF_W-1:0]      cutoff_q;
	logic [LMODE_W-1:0]       lmode_q;
	logic [LWIDTH_W-1:0]      lwidth_q;
	logic [LSTAGE_W-1:0]      lstage_q;
	logic signed [INIT_W-1:0] init_low_q;
	logic signed [INIT_W-1:0] init_band_q;

	// filter state and per-item working registers
	logic signed [STATE_W-1:0]  low_q;
	logic signed [STATE_W-1:0]  band_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [RES_W-1:0]           res_q;
	logic signed [CALC_W-1:0]   d_q;
	logic signed [CALC_W-1:0]   h_q;
	logic [OUT_W-1:0]           out_q;
	logic                       out_valid_q;

	logic in_acc;
	logic cfg_wr;
	logic low_done;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [LWIDTH_W-1:0]        lw_eff;
	logic [GAIN_W-1:0]          gain;
	logic signed [CALC_W-1:0]   low_ext;
	logic signed [CALC_W-1:0]   band_ext;

	// shared multiplier
	logic signed [CALC_W-1:0] mul_a;
	logic [GAIN_W-1:0]        mul_m;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [CALC_W-1:0] d_new;
	logic signed [CALC_W-1:0] h_new;
	logic signed [CALC_W-1:0] band_new;
	logic signed [CALC_W-1:0] low_new;
	logic signed [CALC_W-1:0] neg2_low;
	logic signed [CALC_W-1:0] out_sat;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign low_done = (state_q == ST_LOW) & (~out_valid_q | m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_q};
	assign sample_in = signed'(s_tdata[SAMPLE_W-1:0]);

	// limit width clamped to its legal span, gain from the cutoff word
	assign lw_eff = (lwidth_q < LWIDTH_MIN) ? LWIDTH_MIN :
		(lwidth_q > LWIDTH_MAX) ? LWIDTH_MAX : lwidth_q;
	assign gain = (cutoff_q == CUTOFF_FULL) ? GAIN_FULL : {2'b01, cutoff_q[8:1]};

	assign low_ext  = {{(CALC_W-STATE_W){low_q[STATE_W-1]}}, low_q};
	assign band_ext = {{(CALC_W-STATE_W){band_q[STATE_W-1]}}, band_q};

	// optional limiting at the selected stage
	function automatic logic signed [CALC_W-1:0] limit_at(
		input logic signed [CALC_W-1:0] v,
		input logic [LSTAGE_W-1:0] stage
	);
		logic signed [CALC_W-1:0] r;
		r = v;
		if (stage == lstage_q) begin
			case (lmode_q)
				LIM_SAT:  r = sat_to(v, {1'b0, lw_eff});
				LIM_WRAP: r = wrap_to(v, lw_eff);
				default:  r = v;
			endcase
		end
		return r;
	endfunction

	// multiplier operand select
	always_comb begin
		case (state_q)
			ST_DAMP: begin
				mul_a = band_ext;
				mul_m = {2'b00, res_q};
			end
			ST_BAND: begin
				mul_a = h_q;
				mul_m = gain;
			end
			ST_LOW: begin
				mul_a = band_ext;
				mul_m = gain;
			end
			default: begin
				mul_a = band_ext;
				mul_m = gain;
			end
		endcase
	end

	assign prod = mul_a * signed'({1'b0, mul_m});

	// datapath after the multiplier
	always_comb begin
		logic signed [PROD_W-1:0] dq;
		logic signed [PROD_W-1:0] inc;
		logic signed [PROD_W-1:0] li;
		logic signed [CALC_W-1:0] bsum;
		logic signed [CALC_W-1:0] lsum;
		// damping: 2 * ceil(res * band / 256)
		dq    = (prod + PROD_W'(255)) >>> 8;
		d_new = limit_at(CALC_W'(dq <<< 1), STG_DAMP);
		// highpass difference
		h_new = limit_at(CALC_W'(x_q) - low_ext - d_q, STG_HP);
		// band update: floor(k * h / 512)
		inc      = prod >>> 9;
		bsum     = band_ext + limit_at(CALC_W'(inc), STG_BINC);
		band_new = sat_to(limit_at(bsum, STG_STATE), 7'(STATE_W));
		// low update: ceil(k * band / 512) on the new band
		li      = (prod + PROD_W'(511)) >>> 9;
		lsum    = low_ext + limit_at(CALC_W'(li), STG_LINC);
		low_new = sat_to(limit_at(lsum, STG_STATE), 7'(STATE_W));
		neg2_low = -(low_new <<< 1);
		out_sat  = sat_to(neg2_low, 7'(OUT_W));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_DAMP;
				ST_DAMP: state_q <= ST_HP;
				ST_HP:   state_q <= ST_BAND;
				ST_BAND: state_q <= ST_LOW;
				ST_LOW:  if (low_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// filter state, restart load and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			band_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && s_tuser) begin
				low_q  <= {{(STATE_W-INIT_W){init_low_q[INIT_W-1]}}, init_low_q};
				band_q <= {{(STATE_W-INIT_W){init_band_q[INIT_W-1]}}, init_band_q};
			end
			if (state_q == ST_BAND)
				band_q <= band_new[STATE_W-1:0];
			if (low_done)
				low_q <= low_new[STATE_W-1:0];
			if (low_done)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			// halve toward zero
			x_q   <= (sample_in + signed'(SAMPLE_W'(s_tdata[SAMPLE_W-1]))) >>> 1;
			res_q <= s_tdata[SAMPLE_W+RES_W-1:SAMPLE_W];
		end
		if (state_q == ST_DAMP)
			d_q <= d_new;
		if (state_q == ST_HP)
			h_q <= h_new;
		if (low_done)
			out_q <= out_sat[OUT_W-1:0];
		prod_q <= prod;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q    <= '0;
			lmode_q     <= LIM_NONE;
			lwidth_q    <= LWIDTH_MIN;
			lstage_q    <= STG_STATE;
			init_low_q  <= '0;
			init_band_q <= '0;
		end else if (cfg_wr && pready) begin
			case (paddr[4:2])
				REG_CUTOFF:    cutoff_q    <= pwdata[CUTOFF_W-1:0];
				REG_LMODE:     lmode_q     <= pwdata[LMODE_W-1:0];
				REG_LWIDTH:    lwidth_q    <= pwdata[LWIDTH_W-1:0];
				REG_LSTAGE:    lstage_q    <= pwdata[LSTAGE_W-1:0];
				REG_INIT_LOW:  init_low_q  <= signed'(pwdata[INIT_W-1:0]);
				REG_INIT_BAND: init_band_q <= signed'(pwdata[INIT_W-1:0]);
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			REG_CUTOFF:    prdata = {{(32-CUTOFF_W){1'b0}}, cutoff_q};
			REG_LMODE:     prdata = {{(32-LMODE_W){1'b0}}, lmode_q};
			REG_LWIDTH:    prdata = {{(32-LWIDTH_W){1'b0}}, lwidth_q};
			REG_LSTAGE:    prdata = {{(32-LSTAGE_W){1'b0}}, lstage_q};
			REG_INIT_LOW:  prdata = {{(32-INIT_W){init_low_q[INIT_W-1]}}, init_low_q};
			REG_INIT_BAND: prdata = {{(32-INIT_W){init_band_q[INIT_W-1]}}, init_band_q};
			default:       prdata = '0;
		endcase
	end

	// accepted item starts the damping step
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_DAMP)
		else $error("accepted item did not start the sequencer");

	// a new result only comes from the low update step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_LOW)
		else $error("result raised outside the low update step");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOW && m_tvalid && !m_tready) |=> state_q == ST_LOW)
		else $error("low update finished while output still stalled");

	// the damping product is registered for the next step
	a_prod_reg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DAMP |=> prod_q == $past(prod))
		else $error("shared multiplier result not captured");

endmodule
